FILE: design/scmd_pkg.sv
// Package for the stereo chorus block: sizes, register map and the sine table.
// No dependencies; imported by the top level and its checker.
`default_nettype none
package scmd_pkg;
    localparam int LINE_DEPTH   = 8192;
    localparam int ADDR_W       = $clog2(LINE_DEPTH);
    localparam int POS_W        = ADDR_W + 8;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_W       = $clog2(SINE_ENTRIES);
    localparam int SAMPLE_BITS  = 16;

    localparam logic [2:0] REG_BYPASS   = 3'd0;
    localparam logic [2:0] REG_WET_MIX  = 3'd1;
    localparam logic [2:0] REG_DEPTH    = 3'd2;
    localparam logic [2:0] REG_FEEDBACK = 3'd3;
    localparam logic [2:0] REG_BASE     = 3'd4;
    localparam logic [2:0] REG_STEP     = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t sine_tab_t [SINE_ENTRIES];

    function automatic sine_tab_t build_sine_tab();
        localparam int Quarter = SINE_ENTRIES / 4;
        sine_tab_t   tab;
        logic [31:0] quad, r, q, t, t2, p;
        logic [63:0] v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            quad = 32'((i / Quarter) % 4);
            r    = 32'(i % Quarter);
            q    = quad[0] ? 32'(Quarter) - r : r;
            t    = 32'((64'(q) << 15) / Quarter);
            t2   = (t * t) >> 15;
            p    = 32'd2611 - ((t2 * 32'd153) >> 15);
            p    = 32'd21167 - ((t2 * p) >> 15);
            p    = 32'd51472 - ((t2 * p) >> 15);
            v    = (64'(t) * 64'(p)) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[i] = quad[1] ? -sample_t'(v[15:0]) : sample_t'(v[15:0]);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    function automatic sample_t sat_sample(input logic signed [39:0] v);
        if (v > 40'sd32767) begin
            return sample_t'(16'h7fff);
        end else if (v < -40'sd32768) begin
            return sample_t'(16'h8000);
        end
        return v[15:0];
    endfunction
endpackage
`default_nettype wire

FILE: design/stereo_chorus_modulated_delay_top.sv
// Stereo chorus: per-channel modulated ring delay with feedback and dry/wet blend.
// Uses scmd_pkg; one shared multiplier sequenced over both channels, one line memory.
// An accepted item passes through the states MUL1 to MIX once per channel, through the shared
// multiplier and the single memory read port, then DONE, where the result is registered once
// the output is free; no new item is accepted until IDLE. A bypassed item goes straight to DONE.
// Reset is synchronous, active low; the delay lines read as zero until written (fill count).
`default_nettype none
module stereo_chorus_modulated_delay_top import scmd_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_left_in,
    input  wire logic signed [15:0] s_right_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_left_out,
    output logic signed [15:0]      m_right_out
);
    localparam logic [3:0] S_IDLE = 4'd0, S_MUL1 = 4'd1, S_MUL2 = 4'd2, S_DLY = 4'd3,
                           S_RDA = 4'd4, S_RDB = 4'd5, S_MULB = 4'd6, S_SUMD = 4'd7,
                           S_FB = 4'd8, S_WR = 4'd9, S_MIX = 4'd10, S_DONE = 4'd11;
    localparam logic [POS_W-1:0] MAX_DELAY = POS_W'((LINE_DEPTH - 1) * 256);

    logic        bypass_reg;
    logic [15:0] wet_mix_reg, depth_reg;
    logic [14:0] feedback_reg;
    logic [19:0] base_reg, step_reg;

    logic [3:0]  state_reg, state_next;
    logic        ch_reg, byp_item_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W:0]   fill_reg;
    logic [31:0] lphase_reg, rphase_reg;
    sample_t     lin_reg, rin_reg, res_l_reg, res_r_reg, d_reg;
    logic [POS_W-1:0] rp_reg;
    logic signed [54:0] prod_reg;
    logic signed [25:0] acc_reg;
    logic [15:0] rdata_reg;
    logic        rvalid_reg;
    logic [15:0] line_mem [2*LINE_DEPTH];
    logic        m_valid_reg;
    sample_t     m_left_reg, m_right_reg;

    logic signed [33:0] mul_a;
    logic signed [20:0] mul_b;
    logic [31:0] phase;
    sample_t     cur_in, samp, sine, wr_val, mix_val;
    logic signed [25:0] offs, dly;
    logic [POS_W-1:0]   dly_c;
    logic [ADDR_W-1:0]  rd_idx;
    logic        rd_ok;
    logic signed [26:0] interp;
    logic        cfg_wr, out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (paddr[4:2])
            REG_BYPASS:   prdata = {31'd0, bypass_reg};
            REG_WET_MIX:  prdata = {16'd0, wet_mix_reg};
            REG_DEPTH:    prdata = {16'd0, depth_reg};
            REG_FEEDBACK: prdata = {17'd0, feedback_reg};
            REG_BASE:     prdata = {12'd0, base_reg};
            REG_STEP:     prdata = {12'd0, step_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign phase  = ch_reg ? rphase_reg : lphase_reg;
    assign cur_in = ch_reg ? rin_reg : lin_reg;
    assign sine   = SINE_TAB[phase[31:32-SINE_W]];
    assign samp   = rvalid_reg ? sample_t'(rdata_reg) : sample_t'(16'd0);
    assign offs   = 26'($signed(prod_reg[54:31]));
    assign dly    = 26'($signed({6'd0, base_reg})) + offs;
    assign interp = 27'(acc_reg) + 27'(prod_reg[25:0]);
    assign wr_val  = sat_sample(40'(cur_in) + prod_reg[54:15]);
    assign mix_val = sat_sample(40'(cur_in) + prod_reg[54:15]);

    always_comb begin
        if (dly < 0) begin
            dly_c = '0;
        end else if (dly > $signed({5'd0, MAX_DELAY})) begin
            dly_c = MAX_DELAY;
        end else begin
            dly_c = dly[POS_W-1:0];
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL1: begin
                mul_a = 34'(sine);
                mul_b = $signed({5'd0, depth_reg});
            end
            S_MUL2: begin
                mul_a = prod_reg[33:0];
                mul_b = $signed({1'b0, base_reg});
            end
            S_RDB: begin
                mul_a = 34'(samp);
                mul_b = 21'(9'd256 - {1'b0, rp_reg[7:0]});
            end
            S_MULB: begin
                mul_a = 34'(samp);
                mul_b = 21'(rp_reg[7:0]);
            end
            S_FB: begin
                mul_a = 34'(d_reg);
                mul_b = $signed({6'd0, feedback_reg});
            end
            S_WR: begin
                mul_a = $signed({18'd0, wet_mix_reg});
                mul_b = 21'(17'(d_reg) - 17'(cur_in));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rd_idx = (state_reg == S_RDB) ? rp_reg[POS_W-1:8] + 1'b1 : rp_reg[POS_W-1:8];
    assign rd_ok  = fill_reg[ADDR_W] || (rd_idx < fill_reg[ADDR_W-1:0]);

    always_ff @(posedge aclk) begin
        if (state_reg == S_WR) begin
            line_mem[{ch_reg, wp_reg}] <= wr_val;
        end
        rdata_reg <= line_mem[{ch_reg, rd_idx}];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) state_next = bypass_reg ? S_DONE : S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_DLY;
            S_DLY:  state_next = S_RDA;
            S_RDA:  state_next = S_RDB;
            S_RDB:  state_next = S_MULB;
            S_MULB: state_next = S_SUMD;
            S_SUMD: state_next = S_FB;
            S_FB:   state_next = S_WR;
            S_WR:   state_next = S_MIX;
            S_MIX:  state_next = ch_reg ? S_DONE : S_MUL1;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= mul_a * mul_b;
        rvalid_reg <= rd_ok;
        if (state_reg == S_DLY) rp_reg <= {wp_reg, 8'd0} - dly_c;
        if (state_reg == S_MULB) acc_reg <= prod_reg[25:0];
        if (state_reg == S_SUMD) d_reg <= interp[23:8];
        if (state_reg == S_MIX) begin
            if (ch_reg) res_r_reg <= mix_val;
            else res_l_reg <= mix_val;
        end
        if (s_valid && s_ready) begin
            lin_reg <= s_left_in;
            rin_reg <= s_right_in;
        end
        if (state_reg == S_DONE && out_free) begin
            m_left_reg  <= byp_item_reg ? lin_reg : res_l_reg;
            m_right_reg <= byp_item_reg ? rin_reg : res_r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ch_reg       <= 1'b0;
            byp_item_reg <= 1'b0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            lphase_reg   <= 32'h0;
            rphase_reg   <= 32'h2000_0000;
            m_valid_reg  <= 1'b0;
            bypass_reg   <= 1'b0;
            wet_mix_reg  <= 16'd16384;
            depth_reg    <= 16'd16384;
            feedback_reg <= 15'd6554;
            base_reg     <= 20'd184320;
            step_reg     <= 20'd89478;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_BYPASS:   bypass_reg   <= pwdata[0];
                    REG_WET_MIX:  wet_mix_reg  <= pwdata[15:0];
                    REG_DEPTH:    depth_reg    <= pwdata[15:0];
                    REG_FEEDBACK: feedback_reg <= pwdata[14:0];
                    REG_BASE:     base_reg     <= pwdata[19:0];
                    REG_STEP:     step_reg     <= pwdata[19:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                byp_item_reg <= bypass_reg;
                ch_reg       <= 1'b0;
            end
            if (state_reg == S_MIX) begin
                ch_reg <= 1'b1;
                if (ch_reg) begin
                    wp_reg     <= wp_reg + 1'b1;
                    lphase_reg <= lphase_reg + {12'd0, step_reg};
                    rphase_reg <= rphase_reg + {12'd0, step_reg};
                    if (!fill_reg[ADDR_W]) fill_reg <= fill_reg + 1'b1;
                end
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/scmd_checker.sv
// Port-level checker for the stereo chorus top level, bound to it below.
// Uses scmd_pkg for the sample type only.
`default_nettype none
module scmd_checker import scmd_pkg::*; (
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    pready,
    input wire logic    s_valid,
    input wire logic    s_ready,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire sample_t m_left_out,
    input wire sample_t m_right_out
);
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second item while busy");
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared one cycle after the item");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_left_out) && $stable(m_right_out)))
        else $error("stalled result changed");
endmodule

bind stereo_chorus_modulated_delay_top scmd_checker u_scmd_checker (
    .aclk(aclk), .aresetn(aresetn), .pready(pready), .s_valid(s_valid),
    .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready),
    .m_left_out(m_left_out), .m_right_out(m_right_out)
);
`default_nettype wire
